FILE: rtl/ipd_frame_deframer_macros.svh
// Assertion helpers for the deframer RTL; ipd_parser includes them.
// Each macro expects clk and arst_n in scope.
`ifndef IPD_FRAME_DEFRAMER_MACROS_SVH
`define IPD_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication.
`define IPD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ipd deframer: same-cycle check failed");

// Next-cycle implication.
`define IPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ipd deframer: next-cycle check failed");

`endif

FILE: rtl/ipd_pkg.sv
`default_nettype none
package ipd_pkg;

	// Parser phase
	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_DIGITS  = 2'd1,
		PH_PAYLOAD = 2'd2
	} ipd_phase_t;

	// Configuration handed to the parser
	typedef struct packed {
		logic [15:0] max_payload;
	} ipd_cfg_t;

	localparam logic [7:0]  CHAR_PLUS  = 8'h2B;
	localparam logic [7:0]  CHAR_COLON = 8'h3A;
	localparam logic [7:0]  CHAR_ZERO  = 8'h30;
	localparam logic [7:0]  CHAR_NINE  = 8'h39;
	localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;
	localparam logic [2:0]  HDR_LAST_POS = 3'd4;

	// Register indexes
	localparam logic REG_MAX_PAYLOAD = 1'b0;

	// Header text "+IPD,"
	function automatic logic [7:0] hdr_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = CHAR_PLUS;
			3'd1: c = 8'h49;
			3'd2: c = 8'h50;
			3'd3: c = 8'h44;
			3'd4: c = 8'h2C;
			default: c = CHAR_PLUS;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/ipd_if.sv
`default_nettype none

// Received byte channel
interface ipd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// Deframed result channel
interface ipd_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  payload_byte;
	logic        byte_valid;
	logic        frame_last;
	logic [15:0] frame_length;
	modport source (output valid, output payload_byte, output byte_valid,
		output frame_last, output frame_length, input ready);
	modport sink   (input valid, input payload_byte, input byte_valid,
		input frame_last, input frame_length, output ready);
endinterface

`default_nettype wire

FILE: rtl/ipd_frame_deframer.sv
// Path: a byte accepted on the input goes through the input register, then the
// result register, before its result, if it makes one, is on the output.
// Throughput: one byte per cycle while the result side is ready; a held result
// stalls the input only once the input register is also full.
// Reset (arst_n low, asynchronous): hunting for the header, counters clear,
// max_payload returns to 1024.
`default_nettype none
module ipd_frame_deframer
	import ipd_pkg::*;
#(
	parameter int MAX_FRAME = 2048
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ipd_rx_if.sink           rx_ch,
	ipd_res_if.source        res_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	ipd_cfg_t cfg;

	// Register block
	ipd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Byte parser
	ipd_parser #(
		.MAX_FRAME (MAX_FRAME)
	) u_parser (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.in_valid         (rx_ch.valid),
		.in_ready         (rx_ch.ready),
		.in_byte          (rx_ch.rx_byte),
		.out_valid        (res_ch.valid),
		.out_ready        (res_ch.ready),
		.out_payload_byte (res_ch.payload_byte),
		.out_byte_valid   (res_ch.byte_valid),
		.out_frame_last   (res_ch.frame_last),
		.out_frame_length (res_ch.frame_length)
	);

endmodule
`default_nettype wire

FILE: rtl/ipd_cfg_regs.sv
`default_nettype none
module ipd_cfg_regs
	import ipd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output ipd_cfg_t         cfg
);

	logic [15:0] max_payload_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// max_payload register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RESET;
		end else if (wr_en && (paddr[2] == REG_MAX_PAYLOAD)) begin
			max_payload_q <= pwdata[15:0];
		end
	end

	// Read back
	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == REG_MAX_PAYLOAD) begin
			prdata = {16'd0, max_payload_q};
		end
	end

	assign cfg.max_payload = max_payload_q;

endmodule
`default_nettype wire

FILE: rtl/ipd_parser.sv
`default_nettype none
`include "ipd_frame_deframer_macros.svh"
module ipd_parser
	import ipd_pkg::*;
#(
	parameter int MAX_FRAME = 2048
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  ipd_cfg_t         cfg,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [7:0]  out_payload_byte,
	output logic             out_byte_valid,
	output logic             out_frame_last,
	output logic      [15:0] out_frame_length
);

	localparam logic [19:0] MaxFrameW = 20'(MAX_FRAME);

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Parser state
	ipd_phase_t  phase_q, phase_d;
	logic [2:0]  match_q, match_d;
	logic [15:0] dlen_q, dlen_d;
	logic [15:0] remain_q, remain_d;
	logic [15:0] deliv_q, deliv_d;

	// Result register
	logic        res_valid_q;
	logic [7:0]  res_byte_q;
	logic        res_bvalid_q;
	logic        res_last_q;
	logic [15:0] res_len_q;

	logic        advance;
	logic        is_digit;
	logic [19:0] dlen_next;
	logic [2:0]  hunt_pos;
	logic        hunt_hit;
	logic        give;
	logic [15:0] deliv_inc;
	logic [15:0] remain_dec;
	logic        pay_last;

	logic        has_res;
	logic [7:0]  res_byte_d;
	logic        res_bvalid_d;
	logic        res_last_d;
	logic [15:0] res_len_d;

	assign advance  = valid_s1 && (!res_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	// Shared decode
	assign is_digit   = (byte_s1 >= CHAR_ZERO) && (byte_s1 <= CHAR_NINE);
	assign dlen_next  = {1'b0, dlen_q, 3'b000} + {3'b000, dlen_q, 1'b0}
		+ {12'd0, byte_s1 - CHAR_ZERO};
	assign hunt_pos   = (phase_q == PH_HUNT) ? match_q : 3'd0;
	assign hunt_hit   = (byte_s1 == hdr_char(hunt_pos));
	assign give       = deliv_q < cfg.max_payload;
	assign deliv_inc  = deliv_q + {15'd0, give};
	assign remain_dec = remain_q - {15'd0, (remain_q != 16'd0)};
	assign pay_last   = (remain_dec == 16'd0);

	// Next state
	always_comb begin
		phase_d  = phase_q;
		match_d  = match_q;
		dlen_d   = dlen_q;
		remain_d = remain_q;
		deliv_d  = deliv_q;
		case (phase_q)
			PH_DIGITS: begin
				if (is_digit) begin
					if (dlen_next > MaxFrameW) begin
						phase_d = PH_HUNT;
						match_d = 3'd0;
						dlen_d  = 16'd0;
					end else begin
						dlen_d = dlen_next[15:0];
					end
				end else if (byte_s1 == CHAR_COLON) begin
					if (dlen_q == 16'd0) begin
						phase_d = PH_HUNT;
						match_d = 3'd0;
					end else begin
						phase_d  = PH_PAYLOAD;
						remain_d = dlen_q;
						deliv_d  = 16'd0;
					end
				end else begin
					// restart hunt; a '+' counts as header start
					phase_d = PH_HUNT;
					match_d = hunt_hit ? 3'd1 : 3'd0;
				end
			end
			PH_PAYLOAD: begin
				deliv_d  = deliv_inc;
				remain_d = remain_dec;
				if (pay_last) begin
					phase_d = PH_HUNT;
					match_d = 3'd0;
				end
			end
			default: begin
				// hunting (unused code behaves the same)
				phase_d = PH_HUNT;
				if (hunt_hit && (hunt_pos == HDR_LAST_POS)) begin
					phase_d = PH_DIGITS;
					match_d = 3'd0;
					dlen_d  = 16'd0;
				end else if (hunt_hit) begin
					match_d = hunt_pos + 3'd1;
				end else begin
					match_d = (byte_s1 == CHAR_PLUS) ? 3'd1 : 3'd0;
				end
			end
		endcase
	end

	// Result generation
	always_comb begin
		has_res      = 1'b0;
		res_byte_d   = 8'd0;
		res_bvalid_d = 1'b0;
		res_last_d   = 1'b0;
		res_len_d    = 16'd0;
		case (phase_q)
			PH_DIGITS: begin
				// empty frame ends at the colon
				if (!is_digit && (byte_s1 == CHAR_COLON) && (dlen_q == 16'd0)) begin
					has_res    = 1'b1;
					res_last_d = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				has_res      = give || pay_last;
				res_byte_d   = give ? byte_s1 : 8'd0;
				res_bvalid_d = give;
				res_last_d   = pay_last;
				res_len_d    = pay_last ? deliv_inc : 16'd0;
			end
			default: begin
				has_res = 1'b0;
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			match_q  <= 3'd0;
			dlen_q   <= 16'd0;
			remain_q <= 16'd0;
			deliv_q  <= 16'd0;
		end else if (advance) begin
			phase_q  <= phase_d;
			match_q  <= match_d;
			dlen_q   <= dlen_d;
			remain_q <= remain_d;
			deliv_q  <= deliv_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= has_res;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			res_byte_q   <= res_byte_d;
			res_bvalid_q <= res_bvalid_d;
			res_last_q   <= res_last_d;
			res_len_q    <= res_len_d;
		end
	end

	assign out_valid        = res_valid_q;
	assign out_payload_byte = res_byte_q;
	assign out_byte_valid   = res_bvalid_q;
	assign out_frame_last   = res_last_q;
	assign out_frame_length = res_len_q;

	// A result that does not end a frame always carries a byte
	`IPD_ASSERT_IMPL(a_mid_has_byte, res_valid_q && !res_last_q, res_bvalid_q)
	// Length is only reported on the last result
	`IPD_ASSERT_IMPL(a_len_on_last, res_valid_q && !res_last_q, res_len_q == 16'd0)
	// In payload there is always at least one byte still expected
	`IPD_ASSERT_IMPL(a_payload_remain, phase_q == PH_PAYLOAD, remain_q != 16'd0)
	// A produced result shows up on the output
	`IPD_ASSERT_NEXT(a_res_loaded, advance && has_res, res_valid_q)

endmodule
`default_nettype wire

FILE: tb/sv/tb_ipd_frame_deframer.sv
`timescale 1ns / 1ps

module tb_ipd_frame_deframer;
	import ipd_pkg::*;

	localparam int MAX_FRAME = 2048;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int DRAIN_CYCLES = 10;
	localparam int HOLD_CYCLES = 300;
	localparam int ITEMS_PER_PHASE = 250;
	localparam int NUM_PHASES = 6;
	localparam logic [39:0] HDR_TEXT = "+IPD,";
	localparam logic [2:0] ADDR_MAX_PAYLOAD = {REG_MAX_PAYLOAD, 2'b00};
	// byte address of register index 1: nothing lives there
	localparam logic [2:0] ADDR_UNUSED = 3'd4;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        byte_valid;
		logic        frame_last;
		logic [15:0] frame_length;
	} deframe_res_t;

	typedef enum {ROW_PREDICT, ROW_QUIET, ROW_TYPED, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t    kind;
		logic [7:0]   data_byte;
		logic [2:0]   addr;
		logic [15:0]  cfg_val;
		deframe_res_t typed;
	} dir_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	ipd_rx_if  rx_ch ();
	ipd_res_if res_ch ();

	ipd_frame_deframer #(.MAX_FRAME(MAX_FRAME)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx_ch   (rx_ch),
		.res_ch  (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Parser state mirrored by the predictor
	ipd_phase_t  phase_q = PH_HUNT;
	logic [2:0]  match_q = '0;
	logic [15:0] decl_q = '0;
	logic [15:0] remain_q = '0;
	logic [15:0] deliv_q = '0;
	logic [15:0] max_pl = MAX_PAYLOAD_RESET;

	deframe_res_t deframed_due[$];
	dir_row_t     dir_rows[$];

	int fail_count = 0;
	int bytes_sent = 0;
	int results_seen = 0;
	int frames_seen = 0;
	int cfg_writes = 0;
	int cycle_count = 0;
	bit rx_calm = 1'b0;
	bit res_calm = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Header matcher used while hunting
	function automatic void hunt_match(input logic [7:0] b);
		logic [2:0] pos;
		pos = (match_q > HDR_LAST_POS) ? 3'd0 : match_q;
		if (b == HDR_TEXT[8 * (HDR_LAST_POS - pos) +: 8]) begin
			if (pos == HDR_LAST_POS) begin
				phase_q = PH_DIGITS;
				decl_q = '0;
				match_q = '0;
				return;
			end
			match_q = pos + 3'd1;
		end else begin
			// a stray '+' still counts as a fresh header start
			match_q = (b == CHAR_PLUS) ? 3'd1 : 3'd0;
		end
		phase_q = PH_HUNT;
	endfunction

	// Advance the parser by one byte; returns 1 when a result is due
	function automatic bit deframe_step(input logic [7:0] b, output deframe_res_t r);
		int unsigned n;
		bit give;
		bit last;
		r = '0;
		case (phase_q)
			PH_DIGITS: begin
				if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
					n = decl_q * 10 + (b - CHAR_ZERO);
					if (n > MAX_FRAME) begin
						phase_q = PH_HUNT;
						match_q = '0;
						decl_q = '0;
					end else begin
						decl_q = n[15:0];
					end
					return 1'b0;
				end
				if (b == CHAR_COLON) begin
					if (decl_q == '0) begin
						phase_q = PH_HUNT;
						match_q = '0;
						r.frame_last = 1'b1;
						return 1'b1;
					end
					phase_q = PH_PAYLOAD;
					remain_q = decl_q;
					deliv_q = '0;
					return 1'b0;
				end
				match_q = '0;
				hunt_match(b);
				return 1'b0;
			end
			PH_PAYLOAD: begin
				give = (deliv_q < max_pl);
				if (give)
					deliv_q = deliv_q + 16'd1;
				if (remain_q != '0)
					remain_q = remain_q - 16'd1;
				last = (remain_q == '0);
				if (last) begin
					phase_q = PH_HUNT;
					match_q = '0;
				end
				if (!give && !last)
					return 1'b0;
				r.payload_byte = give ? b : 8'd0;
				r.byte_valid = give;
				r.frame_last = last;
				r.frame_length = last ? deliv_q : 16'd0;
				return 1'b1;
			end
			default: begin
				hunt_match(b);
				return 1'b0;
			end
		endcase
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 1;
		if (r < 95)
			return $urandom_range(2, 4);
		return $urandom_range(10, 40);
	endfunction

	// Directed table builders
	function automatic void add_row(input row_kind_t kind, input logic [7:0] b,
		input deframe_res_t typed = '0);
		dir_row_t r;
		r.kind = kind;
		r.data_byte = b;
		r.addr = '0;
		r.cfg_val = '0;
		r.typed = typed;
		dir_rows.push_back(r);
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_row(ROW_PREDICT, s[i]);
	endfunction

	function automatic void add_cfg(input logic [2:0] addr, input logic [15:0] val);
		dir_row_t r;
		r.kind = ROW_CFG;
		r.data_byte = '0;
		r.addr = addr;
		r.cfg_val = val;
		r.typed = '0;
		dir_rows.push_back(r);
	endfunction

	// Offer one byte, wait for the request to be taken, then predict
	task automatic send_byte(input logic [7:0] b, input row_kind_t kind = ROW_PREDICT,
		input deframe_res_t typed = '0);
		int gap;
		bit has;
		deframe_res_t r;
		gap = (!rx_calm && $urandom_range(0, 99) < 30) ? gap_len() : 0;
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		bytes_sent++;
		has = deframe_step(b, r);
		if (kind == ROW_TYPED)
			deframed_due.push_back(typed);
		else if (kind == ROW_PREDICT && has)
			deframed_due.push_back(r);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Stop offering and let the pipeline run dry
	task automatic settle();
		rx_ch.valid <= 1'b0;
		while (deframed_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Setup then access phase; upper data bits are junk the block must drop
	task automatic reg_write(input logic [2:0] addr, input logic [15:0] val);
		logic [15:0] junk;
		junk = 16'($urandom_range(0, 65535));
		settle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {junk, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		cfg_writes++;
		if (addr == ADDR_MAX_PAYLOAD)
			max_pl = val;
	endtask

	// Well-formed frame with random payload; empty digits or leading zeros now and then
	task automatic random_frame(input int len, input bit plus_sent);
		string hdr;
		string digits;
		int zeros;
		if (plus_sent)
			hdr = "IPD,";
		else
			hdr = "+IPD,";
		if (len == 0 && $urandom_range(0, 1))
			digits = "";
		else
			digits = $sformatf("%0d", len);
		zeros = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
		repeat (zeros) digits = {"0", digits};
		send_text({hdr, digits, ":"});
		repeat (len) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic random_sequence();
		int pick;
		int r;
		int len;
		logic [7:0] b;
		string pool;
		string hdr;
		pool = "+IPD,:09";
		hdr = "+IPD,";
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			r = $urandom_range(0, 99);
			if (r < 65)
				len = $urandom_range(0, 12);
			else if (r < 95)
				len = $urandom_range(13, 64);
			else
				len = $urandom_range(65, 300);
			random_frame(len, 1'b0);
		end else if (pick < 80) begin
			// line noise, biased toward header characters
			repeat ($urandom_range(1, 8)) begin
				if ($urandom_range(0, 1))
					b = pool[$urandom_range(0, pool.len() - 1)];
				else
					b = 8'($urandom_range(0, 255));
				send_byte(b);
			end
		end else if (pick < 88) begin
			// header cut short by an arbitrary byte
			send_text(hdr.substr(0, $urandom_range(0, 3)));
			send_byte(8'($urandom_range(0, 255)));
		end else if (pick < 94) begin
			// header, maybe digits, then a stray byte or a '+' that starts a new frame
			send_text(hdr);
			if ($urandom_range(0, 1))
				send_text($sformatf("%0d", $urandom_range(0, 999)));
			if ($urandom_range(0, 1)) begin
				send_byte(CHAR_PLUS);
				random_frame($urandom_range(0, 12), 1'b1);
			end else begin
				do
					b = 8'($urandom_range(0, 255));
				while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_COLON);
				send_byte(b);
			end
		end else begin
			// declared length over the limit
			len = $urandom_range(0, 1) ? MAX_FRAME + 1 : $urandom_range(MAX_FRAME + 1, 65535);
			send_text({hdr, $sformatf("%0d", len)});
			send_byte(CHAR_COLON);
			repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// Result side: random back-pressure plus one long hold-off
	initial begin : result_monitor
		int stall_left;
		deframe_res_t got;
		deframe_res_t want;
		stall_left = 0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				got = {res_ch.payload_byte, res_ch.byte_valid, res_ch.frame_last,
					res_ch.frame_length};
				results_seen++;
				if (got.frame_last)
					frames_seen++;
				if (deframed_due.size() == 0) begin
					$error("result with nothing pending: byte %02h valid %0b last %0b len %0d",
						got.payload_byte, got.byte_valid, got.frame_last, got.frame_length);
					fail_count++;
				end else begin
					want = deframed_due.pop_front();
					if (got.payload_byte !== want.payload_byte) begin
						$error("payload_byte: expected %02h, got %02h",
							want.payload_byte, got.payload_byte);
						fail_count++;
					end
					if (got.byte_valid !== want.byte_valid) begin
						$error("byte_valid: expected %0b, got %0b",
							want.byte_valid, got.byte_valid);
						fail_count++;
					end
					if (got.frame_last !== want.frame_last) begin
						$error("frame_last: expected %0b, got %0b",
							want.frame_last, got.frame_last);
						fail_count++;
					end
					if (got.frame_length !== want.frame_length) begin
						$error("frame_length: expected %0d, got %0d",
							want.frame_length, got.frame_length);
						fail_count++;
					end
				end
			end
			if (hold_req && !hold_done) begin
				stall_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else if (!res_calm && $urandom_range(0, 99) < 25) begin
				res_ch.ready <= 1'b0;
				stall_left = gap_len() - 1;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ipd_frame_deframer: mismatch");
		$finish;
	end

	initial begin : stimulus
		logic [15:0] cfg_plan[NUM_PHASES];
		int target;
		rx_ch.valid <= 1'b0;
		rx_ch.rx_byte <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;

		// Directed: stray '+', stray byte after a header, zero-length frame,
		// oversize length, swallowed bytes and a limit change inside a frame
		add_text("++IPD,+IPD,");
		add_row(ROW_TYPED, CHAR_COLON, deframe_res_t'{8'h00, 1'b0, 1'b1, 16'd0});
		add_text("+IPD,3000");
		add_cfg(ADDR_MAX_PAYLOAD, 16'd0);
		add_cfg(ADDR_UNUSED, 16'hFFFF);
		add_text("+IPD,3:");
		add_row(ROW_QUIET, 8'hFF);
		add_cfg(ADDR_MAX_PAYLOAD, 16'd1);
		add_row(ROW_TYPED, 8'h00, deframe_res_t'{8'h00, 1'b1, 1'b0, 16'd0});
		add_row(ROW_TYPED, "A", deframe_res_t'{8'h00, 1'b0, 1'b1, 16'd1});

		cfg_plan[0] = 16'hFFFF;
		cfg_plan[1] = 16'd0;
		cfg_plan[2] = 16'd1;
		cfg_plan[3] = MAX_PAYLOAD_RESET;
		cfg_plan[4] = 16'($urandom_range(2, 40));
		cfg_plan[5] = 16'($urandom_range(0, 65535));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG)
				reg_write(dir_rows[i].addr, dir_rows[i].cfg_val);
			else
				send_byte(dir_rows[i].data_byte, dir_rows[i].kind, dir_rows[i].typed);
		end

		// Random phases, one limit setting each
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			reg_write(ADDR_MAX_PAYLOAD, cfg_plan[ph]);
			// first phase: sender never pauses while the result side holds off
			rx_calm = (ph == 0) || ($urandom_range(0, 3) == 0);
			res_calm = ($urandom_range(0, 3) == 0);
			if (ph == 0)
				hold_req = 1'b1;
			if (ph == 3)
				random_frame(MAX_FRAME, 1'b0);
			target = bytes_sent + ITEMS_PER_PHASE;
			while (bytes_sent < target)
				random_sequence();
		end

		settle();
		$display("covered %0d bytes in, %0d results out, %0d frame ends, %0d register writes",
			bytes_sent, results_seen, frames_seen, cfg_writes);
		$display("limits swept: 0, 1, small, reset value, random and 65535; %0d cycles",
			cycle_count);
		if (fail_count == 0)
			$display("ipd_frame_deframer: match");
		else
			$display("ipd_frame_deframer: mismatch");
		$finish;
	end

endmodule
